[design/ssb_pkg.sv]
// shared types and constants of the seam smoothstep blend
package ssb_pkg;

  // field widths
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 12;
  localparam int DIM_W   = 13;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SEAM_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEAM_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEAM_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEAM_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_ALONG_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

  // largest image dimension the bounds check accepts
  localparam logic [DIM_W:0] MAX_DIM = 14'd4096;

  localparam logic [DIM_W-1:0] RESET_IMAGE_DIM = 13'd4096;

  // ramp arithmetic, 65536 is 1.0
  localparam int Q_W    = 17;
  localparam int TSQ_W  = 33;
  localparam int LIN_W  = 18;
  localparam int PROD_W = 49;
  localparam int REM_W  = DIM_W + 1;

  localparam logic [LIN_W-1:0]  THREE_Q16  = 18'd196608;
  localparam logic [PROD_W-1:0] ROUND_HALF = 49'h0_0000_8000_0000;

  // divider pipeline shape
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef struct packed {
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
    logic [CHAN_W-1:0]  first_red;
    logic [CHAN_W-1:0]  first_green;
    logic [CHAN_W-1:0]  first_blue;
    logic [CHAN_W-1:0]  second_red;
    logic [CHAN_W-1:0]  second_green;
    logic [CHAN_W-1:0]  second_blue;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [CHAN_W-1:0]  blend_red;
    logic [CHAN_W-1:0]  blend_green;
    logic [CHAN_W-1:0]  blend_blue;
  } out_item_t;

endpackage

[design/ssb_divider.sv]
// pipelined restoring divider for the ramp position, up to four quotient bits per stage
module ssb_divider (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ssb_pkg::COORD_W-1:0]  pos,
  input  logic [ssb_pkg::DIM_W-1:0]    denom,
  output logic [ssb_pkg::Q_W-1:0]      quot
);

  localparam int STAGES = ssb_pkg::DIV_STAGES;
  localparam int STEPS  = ssb_pkg::DIV_STEPS;
  localparam int REM_W  = ssb_pkg::REM_W;
  localparam int DIM_W  = ssb_pkg::DIM_W;
  localparam int Q_W    = ssb_pkg::Q_W;

  logic [REM_W-1:0] rem_q  [STAGES];
  logic [DIM_W-1:0] den_q  [STAGES];
  logic [Q_W-1:0]   quo_q  [STAGES];

  logic [REM_W-1:0] rem_in [STAGES];
  logic [DIM_W-1:0] den_in [STAGES];
  logic [Q_W-1:0]   quo_in [STAGES];

  logic [REM_W-1:0] rem_next [STAGES];
  logic [Q_W-1:0]   quo_next [STAGES];

  // stage sources: the ports for the first stage, the previous stage otherwise
  always_comb begin
    rem_in[0] = REM_W'(pos);
    den_in[0] = denom;
    quo_in[0] = '0;
    for (int g = 1; g < STAGES; g++) begin
      rem_in[g] = rem_q[g-1];
      den_in[g] = den_q[g-1];
      quo_in[g] = quo_q[g-1];
    end
  end

  // compare, subtract, shift; the first step yields the integer bit of the ramp
  always_comb begin
    for (int g = 0; g < STAGES; g++) begin
      rem_next[g] = rem_in[g];
      quo_next[g] = quo_in[g];
      for (int k = 0; k < STEPS; k++) begin
        if (g * STEPS + k < Q_W) begin
          if (rem_next[g] >= REM_W'(den_in[g])) begin
            rem_next[g] = rem_next[g] - REM_W'(den_in[g]);
            quo_next[g] = {quo_next[g][Q_W-2:0], 1'b1};
          end else begin
            quo_next[g] = {quo_next[g][Q_W-2:0], 1'b0};
          end
          rem_next[g] = {rem_next[g][REM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < STAGES; g++) begin
        rem_q[g] <= rem_next[g];
        den_q[g] <= den_in[g];
        quo_q[g] <= quo_next[g];
      end
    end
  end

  assign quot = quo_q[STAGES-1];

endmodule

[design/seam_smoothstep_blend.sv]
// seam smoothstep blend: crossfades tile pixel pairs across an overlap seam
// throughput: one request per clock while the output is not stalled; the 17-bit ramp divider is split over 5 stages
// a stall on the output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active high): registers take their defaults, pipeline empties
// requests that fall outside the seam or the image leave no result
module seam_smoothstep_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ssb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssb_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssb_pkg::out_item_t              out_data
);

  localparam int COORD_W = ssb_pkg::COORD_W;
  localparam int CHAN_W  = ssb_pkg::CHAN_W;
  localparam int DIM_W   = ssb_pkg::DIM_W;
  localparam int Q_W     = ssb_pkg::Q_W;
  localparam int TSQ_W   = ssb_pkg::TSQ_W;
  localparam int LIN_W   = ssb_pkg::LIN_W;
  localparam int PROD_W  = ssb_pkg::PROD_W;
  localparam int DIFF_W  = CHAN_W + 1;
  localparam int DPROD_W = DIFF_W + Q_W + 1;
  localparam int SUM_W   = DPROD_W;

  // pipeline positions: check stage, divider, square, cube, round, lane multiply
  localparam int N_STG   = 1 + ssb_pkg::DIV_STAGES + 4;
  localparam int T_STG   = ssb_pkg::DIV_STAGES;
  localparam int S_STG   = T_STG + 3;
  localparam int MUL_STG = T_STG + 4;

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // what travels beside the arithmetic
  typedef struct packed {
    logic [COORD_W-1:0]           pix_x;
    logic [COORD_W-1:0]           pix_y;
    logic [2:0][CHAN_W-1:0]       first;
    logic [2:0][CHAN_W-1:0]       second;
  } side_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] seam_x;
  logic [COORD_W-1:0] seam_y;
  logic [DIM_W-1:0]   seam_width;
  logic [DIM_W-1:0]   seam_height;
  logic               ramp_along_x;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      seam_x       <= '0;
      seam_y       <= '0;
      seam_width   <= '0;
      seam_height  <= '0;
      ramp_along_x <= 1'b1;
      image_width  <= ssb_pkg::RESET_IMAGE_DIM;
      image_height <= ssb_pkg::RESET_IMAGE_DIM;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssb_pkg::REG_SEAM_X:       seam_x       <= cfg_data[COORD_W-1:0];
        ssb_pkg::REG_SEAM_Y:       seam_y       <= cfg_data[COORD_W-1:0];
        ssb_pkg::REG_SEAM_WIDTH:   seam_width   <= cfg_data[DIM_W-1:0];
        ssb_pkg::REG_SEAM_HEIGHT:  seam_height  <= cfg_data[DIM_W-1:0];
        ssb_pkg::REG_RAMP_ALONG_X: ramp_along_x <= cfg_data[0];
        ssb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        ssb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: the whole pipe advances unless a finished result is stuck
  // ---------------------------------------------------------------------------
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic  vld_q  [N_STG];
  side_t side_q [N_STG];

  // ---------------------------------------------------------------------------
  // stage 1: seam and image checks, output coordinate, ramp operands
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] ox;
  logic [DIM_W-1:0] oy;
  logic [DIM_W-1:0] bound_w;
  logic [DIM_W-1:0] bound_h;
  logic [DIM_W-1:0] ramp_len;
  logic             keep;
  side_t            side_in;

  logic [COORD_W-1:0] pos_q;
  logic [DIM_W-1:0]   denom_q;

  always_comb begin
    ox = DIM_W'(seam_x) + DIM_W'(in_data.off_x);
    oy = DIM_W'(seam_y) + DIM_W'(in_data.off_y);
    // image sizes above the limit clamp to it; a zero size rejects everything
    bound_w = ({1'b0, image_width} > ssb_pkg::MAX_DIM) ?
              ssb_pkg::MAX_DIM[DIM_W-1:0] : image_width;
    bound_h = ({1'b0, image_height} > ssb_pkg::MAX_DIM) ?
              ssb_pkg::MAX_DIM[DIM_W-1:0] : image_height;
    // a zero overlap size fails the offset compare on its own
    keep = (DIM_W'(in_data.off_x) < seam_width) &&
           (DIM_W'(in_data.off_y) < seam_height) &&
           (ox < bound_w) && (oy < bound_h);
    ramp_len = ramp_along_x ? seam_width : seam_height;

    side_in.pix_x     = ox[COORD_W-1:0];
    side_in.pix_y     = oy[COORD_W-1:0];
    side_in.first[0]  = in_data.first_red;
    side_in.first[1]  = in_data.first_green;
    side_in.first[2]  = in_data.first_blue;
    side_in.second[0] = in_data.second_red;
    side_in.second[1] = in_data.second_green;
    side_in.second[2] = in_data.second_blue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_q     <= ramp_along_x ? in_data.off_x : in_data.off_y;
      // single pixel ramp divides by one, so the position stays at zero
      denom_q   <= (ramp_len > DIM_W'(1)) ? ramp_len - DIM_W'(1) : DIM_W'(1);
    end
  end

  // valid bits ride along, rejected requests enter as bubbles
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_STG; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid && keep;
      for (int i = 1; i < N_STG; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < N_STG; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2..6: t = floor(pos * 65536 / denom), never above 1.0
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0] ramp_t;

  ssb_divider u_divider (
    .clk   (clk),
    .en    (en),
    .pos   (pos_q),
    .denom (denom_q),
    .quot  (ramp_t)
  );

  // ---------------------------------------------------------------------------
  // stages 7..9: smoothstep s = round(t*t*(3 - 2t))
  // ---------------------------------------------------------------------------
  logic [2*Q_W-1:0]       tsq_full;
  logic [TSQ_W-1:0]       tsq_q;
  logic [LIN_W-1:0]       lin_q;
  logic [TSQ_W+LIN_W-1:0] cube_full;
  logic [PROD_W-1:0]      cube_q;
  logic [PROD_W-1:0]      cube_rnd;
  logic [Q_W-1:0]         s_q;

  assign tsq_full  = ramp_t * ramp_t;
  assign cube_full = tsq_q * lin_q;
  assign cube_rnd  = cube_q + ssb_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      tsq_q  <= tsq_full[TSQ_W-1:0];
      lin_q  <= ssb_pkg::THREE_Q16 - {ramp_t, 1'b0};
      cube_q <= cube_full[PROD_W-1:0];
      // the rounded weight tops out at exactly 1.0
      s_q    <= cube_rnd[PROD_W-1 -: Q_W];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: per lane (second - first) * s
  // stage 11: first + that, rounded and saturated, into the output register
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  diff   [3];
  logic signed [DPROD_W-1:0] dprod  [3];
  logic signed [DPROD_W-1:0] dprod_q[3];
  logic signed [SUM_W-1:0]   sum    [3];
  logic [CHAN_W-1:0]         chan   [3];
  logic signed [Q_W:0]       s_ext;

  assign s_ext = $signed({1'b0, s_q});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]  = $signed({1'b0, side_q[S_STG].second[c]}) -
                 $signed({1'b0, side_q[S_STG].first[c]});
      dprod[c] = diff[c] * s_ext;
      sum[c]   = $signed({(SUM_W - CHAN_W - 16)'(0), side_q[MUL_STG].first[c], 16'h0000}) +
                 dprod_q[c] + $signed(SUM_W'(32768));
      priority if (sum[c][SUM_W-1]) begin
        chan[c] = '0;
      end else if (|sum[c][SUM_W-2:CHAN_W+16]) begin
        chan[c] = CHAN_MAX;
      end else begin
        chan[c] = sum[c][CHAN_W+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dprod_q[c] <= dprod[c];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[N_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.pix_x       <= side_q[N_STG-1].pix_x;
      out_data.pix_y       <= side_q[N_STG-1].pix_y;
      out_data.blend_red   <= chan[0];
      out_data.blend_green <= chan[1];
      out_data.blend_blue  <= chan[2];
    end
  end

endmodule

[design/ssb_checker.sv]
// port-level checks for the seam smoothstep blend, bound to the top level
module ssb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_write,
  input logic [ssb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input ssb_pkg::in_item_t               in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input ssb_pkg::out_item_t              out_data
);

  localparam int COORD_W = ssb_pkg::COORD_W;

  // shadow of the seam origin as seen on the write port
  logic [COORD_W-1:0] seam_x_s;
  logic [COORD_W-1:0] seam_y_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      seam_x_s <= '0;
      seam_y_s <= '0;
    end else if (cfg_write) begin
      if (cfg_index == ssb_pkg::REG_SEAM_X) begin
        seam_x_s <= cfg_data[COORD_W-1:0];
      end
      if (cfg_index == ssb_pkg::REG_SEAM_Y) begin
        seam_y_s <= cfg_data[COORD_W-1:0];
      end
    end
  end

  // reset leaves nothing on the output
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a request on offer stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request changed");

  // input side is open exactly when the output register can move
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output state");

  // results never land before the seam origin
  a_coord_in_seam: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pix_x >= seam_x_s) && (out_data.pix_y >= seam_y_s))
    else $error("result coordinate before seam origin");

endmodule

bind seam_smoothstep_blend ssb_checker u_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench of the seam smoothstep blend: predicted pixels vs. block output

module testbench;

  localparam int DRAIN_CYCLES = 24;      // longer than the pipeline latency
  localparam int HOLD_CYCLES  = 300;     // long output stall, fills the pipeline
  localparam int LIMIT_CYCLES = 400000;  // several times the slowest legal run
  localparam int RAND_PHASES  = 11;
  localparam int PHASE_ITEMS  = 103;

  // dut ports, every input known from time zero
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [ssb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  ssb_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ssb_pkg::out_item_t             out_data;

  // our copy of the register file, as the predictor sees it
  logic [ssb_pkg::COORD_W-1:0] seam_col;
  logic [ssb_pkg::COORD_W-1:0] seam_row;
  logic [ssb_pkg::DIM_W-1:0]   seam_w;
  logic [ssb_pkg::DIM_W-1:0]   seam_h;
  logic                        ramp_x;
  logic [ssb_pkg::DIM_W-1:0]   img_w;
  logic [ssb_pkg::DIM_W-1:0]   img_h;

  ssb_pkg::in_item_t  pending_pixels[$];   // requests waiting for the driver
  ssb_pkg::out_item_t expected_pixels[$];  // blended pixels still owed by the block

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;            // random idling on both sides
  bit  hold_arm = 1'b0;           // starts the one long output stall
  int  hold_cnt = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;

  seam_smoothstep_blend uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // crossfade one channel with weight s (65536 is 1.0), rounded, saturated
  function automatic logic [ssb_pkg::CHAN_W-1:0] mix_channel(
      input logic [ssb_pkg::CHAN_W-1:0] a,
      input logic [ssb_pkg::CHAN_W-1:0] b,
      input longint unsigned s);
    longint unsigned v;
    v = (longint'(a) * (65536 - s) + longint'(b) * s + 32768) >> 16;
    if (v > 4095) v = 4095;
    return v[ssb_pkg::CHAN_W-1:0];
  endfunction

  // returns 1 and the blended pixel when the request lands inside seam and image
  function automatic bit blend_predict(input ssb_pkg::in_item_t it,
                                       output ssb_pkg::out_item_t px);
    longint unsigned bw, bh, ox, oy, pos, len, denom, t, s;
    px = '0;
    bw = (img_w > ssb_pkg::MAX_DIM) ? ssb_pkg::MAX_DIM : img_w;
    bh = (img_h > ssb_pkg::MAX_DIM) ? ssb_pkg::MAX_DIM : img_h;
    if (seam_w == 0 || seam_h == 0) return 1'b0;
    if (it.off_x >= seam_w || it.off_y >= seam_h) return 1'b0;
    ox = seam_col + it.off_x;
    oy = seam_row + it.off_y;
    if (ox >= bw || oy >= bh) return 1'b0;
    // ramp position along the chosen axis, then smoothstep shaping
    pos = ramp_x ? it.off_x : it.off_y;
    len = ramp_x ? seam_w : seam_h;
    denom = (len > 1) ? len - 1 : 1;
    t = (pos * 65536) / denom;
    if (t > 65536) t = 65536;
    s = (t * t * (3 * 65536 - 2 * t) + (64'd1 << 31)) >> 32;
    if (s > 65536) s = 65536;
    px.pix_x       = ox[ssb_pkg::COORD_W-1:0];
    px.pix_y       = oy[ssb_pkg::COORD_W-1:0];
    px.blend_red   = mix_channel(it.first_red,   it.second_red,   s);
    px.blend_green = mix_channel(it.first_green, it.second_green, s);
    px.blend_blue  = mix_channel(it.first_blue,  it.second_blue,  s);
    return 1'b1;
  endfunction

  // mostly short gaps, sometimes a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending requests, predicts each one the block takes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit                 took;
    ssb_pkg::out_item_t px;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      took = in_valid && in_ready;
      if (took && blend_predict(in_data, px))
        expected_pixels = {expected_pixels, px};
      if (in_valid && !took) begin
        // request still on offer, payload held
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_data  <= pending_pixels.pop_front();
        in_valid <= 1'b1;
        tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long output stall, counted on its own while the sender keeps going
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && hold_arm && hold_cnt < HOLD_CYCLES)
      hold_cnt <= hold_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // monitor: compares every accepted pixel with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [11:0] exp_v,
                             input logic [11:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ssb_pkg::out_item_t px;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel at (%0d, %0d)", out_data.pix_x, out_data.pix_y);
          mismatches++;
        end else begin
          px = expected_pixels.pop_front();
          check_field("pix_x",       px.pix_x,       out_data.pix_x);
          check_field("pix_y",       px.pix_y,       out_data.pix_y);
          check_field("blend_red",   px.blend_red,   out_data.blend_red);
          check_field("blend_green", px.blend_green, out_data.blend_green);
          check_field("blend_blue",  px.blend_blue,  out_data.blend_blue);
        end
        rx_gap = pick_gap();
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_ready <= !(hold_arm && hold_cnt < HOLD_CYCLES) && rx_gap == 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one register write per clock, driven at the rising edge
  task automatic write_reg(input logic [ssb_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[ssb_pkg::CFG_DATA_W-1:0];
  endtask

  // program all seven registers; only called with the block idle
  task automatic setup_seam(input int sx, input int sy, input int sw, input int sh,
                            input bit rx, input int iw, input int ih);
    write_reg(ssb_pkg::REG_SEAM_X, sx);
    write_reg(ssb_pkg::REG_SEAM_Y, sy);
    write_reg(ssb_pkg::REG_SEAM_WIDTH, sw);
    write_reg(ssb_pkg::REG_SEAM_HEIGHT, sh);
    write_reg(ssb_pkg::REG_RAMP_ALONG_X, rx);
    write_reg(ssb_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(ssb_pkg::REG_IMAGE_HEIGHT, ih);
    @(posedge clk);
    cfg_write <= 1'b0;
    seam_col = sx[ssb_pkg::COORD_W-1:0];
    seam_row = sy[ssb_pkg::COORD_W-1:0];
    seam_w   = sw[ssb_pkg::DIM_W-1:0];
    seam_h   = sh[ssb_pkg::DIM_W-1:0];
    ramp_x   = rx;
    img_w    = iw[ssb_pkg::DIM_W-1:0];
    img_h    = ih[ssb_pkg::DIM_W-1:0];
    @(negedge clk);
  endtask

  task automatic push_pixel(input int ox, input int oy,
                            input int fr, input int fg, input int fb,
                            input int sr, input int sg, input int sb);
    ssb_pkg::in_item_t it;
    it.off_x        = ox[ssb_pkg::COORD_W-1:0];
    it.off_y        = oy[ssb_pkg::COORD_W-1:0];
    it.first_red    = fr[ssb_pkg::CHAN_W-1:0];
    it.first_green  = fg[ssb_pkg::CHAN_W-1:0];
    it.first_blue   = fb[ssb_pkg::CHAN_W-1:0];
    it.second_red   = sr[ssb_pkg::CHAN_W-1:0];
    it.second_green = sg[ssb_pkg::CHAN_W-1:0];
    it.second_blue  = sb[ssb_pkg::CHAN_W-1:0];
    pending_pixels = {pending_pixels, it};
  endtask

  // wait until everything sent has come back, then let the pipeline empty
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // overlap length biased toward the degenerate ramps and the extremes
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r == 1) return 2;
    if (r == 2) return 3;
    if (r < 7)  return $urandom_range(4, 64);
    if (r < 9)  return $urandom_range(65, 4095);
    return 4096;
  endfunction

  // offset inside the part of the overlap that also lies inside the image
  function automatic int pick_offset(input int lim);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return lim - 1;
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic random_phase(input int count);
    int bw, bh, lim_x, lim_y;
    bw = (img_w > ssb_pkg::MAX_DIM) ? ssb_pkg::MAX_DIM : img_w;
    bh = (img_h > ssb_pkg::MAX_DIM) ? ssb_pkg::MAX_DIM : img_h;
    lim_x = (seam_col < bw) ? ((seam_w < bw - seam_col) ? seam_w : bw - seam_col) : 0;
    lim_y = (seam_row < bh) ? ((seam_h < bh - seam_row) ? seam_h : bh - seam_row) : 0;
    for (int i = 0; i < count; i++) begin
      if (lim_x > 0 && lim_y > 0 && $urandom_range(0, 9) < 8)
        push_pixel(pick_offset(lim_x), pick_offset(lim_y),
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        // noise: anywhere in the offset range, mostly dropped by the block
        push_pixel($urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int sx, sy, iw, ih;

    // predictor starts from the register defaults
    seam_col = '0;
    seam_row = '0;
    seam_w   = '0;
    seam_h   = '0;
    ramp_x   = 1'b1;
    img_w    = ssb_pkg::RESET_IMAGE_DIM;
    img_h    = ssb_pkg::RESET_IMAGE_DIM;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults leave the overlap empty, nothing comes out
    push_pixel(0, 0, 100, 200, 300, 400, 500, 600);
    push_pixel(4095, 4095, 4095, 4095, 4095, 0, 0, 0);
    wait_idle();

    // full-size overlap, ramp along x: both ends of the ramp and the middle
    setup_seam(0, 0, 4096, 4096, 1'b1, 4096, 4096);
    push_pixel(0, 0, 0, 0, 0, 4095, 4095, 4095);
    push_pixel(4095, 4095, 4095, 4095, 4095, 0, 0, 0);
    push_pixel(2048, 17, 4095, 1234, 0, 0, 2345, 4095);
    push_pixel(4095, 0, 0, 4095, 2047, 4095, 0, 2048);
    wait_idle();

    // single pixel overlap along y, plus offsets just past it
    setup_seam(10, 20, 1, 1, 1'b0, 4096, 4096);
    push_pixel(0, 0, 4095, 0, 4095, 0, 4095, 0);
    push_pixel(1, 0, 1, 2, 3, 4, 5, 6);
    push_pixel(0, 1, 1, 2, 3, 4, 5, 6);
    wait_idle();

    // seam at the far corner; image sizes above the maximum are clamped
    setup_seam(4095, 4095, 16, 16, 1'b1, 8191, 8191);
    push_pixel(0, 0, 1000, 2000, 3000, 3000, 2000, 1000);
    push_pixel(1, 0, 1, 2, 3, 4, 5, 6);
    push_pixel(0, 1, 1, 2, 3, 4, 5, 6);
    wait_idle();

    // zero-width image drops everything
    setup_seam(0, 0, 4, 4, 1'b1, 0, 4096);
    push_pixel(0, 0, 1, 2, 3, 4, 5, 6);
    wait_idle();

    // one-pixel image with a two-pixel ramp
    setup_seam(0, 0, 2, 2, 1'b0, 1, 1);
    push_pixel(0, 0, 4095, 4095, 4095, 0, 0, 0);
    push_pixel(1, 0, 4095, 4095, 4095, 0, 0, 0);
    push_pixel(0, 1, 4095, 4095, 4095, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)
        setup_seam(0, 0, 4096, 4096, 1'b1, 4096, 4096);
      else if (ph == 1)
        setup_seam(0, 0, 4096, 4096, 1'b0, 4096, 4096);
      else begin
        sx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
        sy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
        iw = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(sx + 1, 4096);
        ih = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(sy + 1, 4096);
        setup_seam(sx, sy, pick_len(), pick_len(), ($urandom_range(0, 1) != 0), iw, ih);
      end
      // every third phase runs flat out on both sides
      gaps_on = (ph % 3 != 0);
      // first phase: stall the output long enough for the input to back up
      if (ph == 0) hold_arm = 1'b1;
      random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[seam_smoothstep_blend.f]
design/ssb_pkg.sv
design/ssb_divider.sv
design/seam_smoothstep_blend.sv
design/ssb_checker.sv
tb/testbench.sv
